### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL of the histogram core.
// Each macro places one labeled concurrent assertion clocked on clk and
// quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition implies a property on the same edge.
`define ASSERT_IMPLY(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

`endif

### rtl/core/fshist_pkg.sv
// ----------------------------------------------------------------------------
// fshist_pkg
// Shared constants and the transaction token carried along the cell chain
// of the first-seen character histogram.
// ----------------------------------------------------------------------------
package fshist_pkg;

  // Default sizes
  localparam int DEF_TABLE_DEPTH = 128;
  localparam int DEF_TALLY_BITS  = 16;

  // Field widths fixed by the interface
  localparam int ACT_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 7;
  localparam int DCNT_W  = 8;
  localparam int ECNT_W  = 16;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_COUNT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // Terminator byte, never counted
  localparam logic [CHAR_W-1:0] TERM_CHAR = 8'h00;

  // Transaction as it travels from cell to cell
  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [CHAR_W-1:0]  char_value;
    logic [INDEX_W-1:0] entry_index;
    logic               present;  // matched an entry already stored
    logic               claimed;  // appended as a new entry
    logic [CHAR_W-1:0]  rchar;    // byte of the touched or read entry
  } token_t;

endpackage

### rtl/core/fshist_cell.sv
// ----------------------------------------------------------------------------
// fshist_cell
// One table entry of the histogram chain. Holds a byte, its tally and a
// used flag, processes the transaction passing by and hands it on through
// its output stage register.
// ----------------------------------------------------------------------------
module fshist_cell #(
  parameter int CELL_IDX   = 0,
  parameter int TALLY_BITS = 16,
  parameter int CNT_W      = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv_i,
  input  logic                    vld_i,
  input  fshist_pkg::token_t      tok_i,
  input  logic [CNT_W-1:0]        used_i,
  input  logic [TALLY_BITS-1:0]   tally_i,
  output logic                    vld_o,
  output fshist_pkg::token_t      tok_o,
  output logic [CNT_W-1:0]        used_o,
  output logic [TALLY_BITS-1:0]   tally_o
);
  import fshist_pkg::*;

  // Entry state
  logic                  cell_used_r, cell_used_nxt;
  logic [CHAR_W-1:0]     byte_r, byte_nxt;
  logic [TALLY_BITS-1:0] tally_r, tally_nxt;

  // Output stage
  logic                  vld_r;
  token_t                tok_r, tok_nxt;
  logic [CNT_W-1:0]      used_r, used_nxt;
  logic [TALLY_BITS-1:0] rcnt_r, rcnt_nxt;

  logic                  is_count, hit, claim, rd, clr;
  logic [TALLY_BITS-1:0] tally_inc;

  // Decode what this transaction does to this entry
  always_comb begin
    is_count  = (tok_i.action == ACT_COUNT) && (tok_i.char_value != TERM_CHAR);
    hit       = cell_used_r && is_count && (byte_r == tok_i.char_value);
    claim     = !cell_used_r && is_count && !tok_i.present && !tok_i.claimed;
    rd        = (tok_i.action == ACT_READ) && cell_used_r &&
                (CELL_IDX == int'(tok_i.entry_index));
    clr       = (tok_i.action == ACT_CLEAR);
    tally_inc = (tally_r == {TALLY_BITS{1'b1}}) ? tally_r : tally_r + 1'b1;
  end

  // Next entry state
  always_comb begin
    cell_used_nxt = cell_used_r;
    byte_nxt      = byte_r;
    tally_nxt     = tally_r;
    priority if (clr) begin
      cell_used_nxt = 1'b0;
    end else if (claim) begin
      cell_used_nxt = 1'b1;
      byte_nxt      = tok_i.char_value;
      tally_nxt     = TALLY_BITS'(1);
    end else if (hit) begin
      tally_nxt     = tally_inc;
    end else begin
      cell_used_nxt = cell_used_r;
    end
  end

  // Next token for the neighbor
  always_comb begin
    tok_nxt         = tok_i;
    rcnt_nxt        = tally_i;
    tok_nxt.present = tok_i.present | hit;
    tok_nxt.claimed = tok_i.claimed | claim;
    priority if (hit) begin
      tok_nxt.rchar = tok_i.char_value;
      rcnt_nxt      = tally_inc;
    end else if (claim) begin
      tok_nxt.rchar = tok_i.char_value;
      rcnt_nxt      = TALLY_BITS'(1);
    end else if (rd) begin
      tok_nxt.rchar = byte_r;
      rcnt_nxt      = tally_r;
    end else begin
      tok_nxt.rchar = tok_i.rchar;
      rcnt_nxt      = tally_i;
    end
    used_nxt = used_i + CNT_W'(cell_used_nxt);
  end

  // Update the entry when a transaction passes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_used_r <= 1'b0;
    end else if (adv_i && vld_i) begin
      cell_used_r <= cell_used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i && vld_i) begin
      byte_r  <= byte_nxt;
      tally_r <= tally_nxt;
    end
  end

  // Advance the stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv_i) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      tok_r  <= tok_nxt;
      used_r <= used_nxt;
      rcnt_r <= rcnt_nxt;
    end
  end

  assign vld_o       = vld_r;
  assign tok_o       = tok_r;
  assign used_o      = used_r;
  assign tally_o     = rcnt_r;

endmodule

### rtl/core/first_seen_char_histogram_core.sv
// ----------------------------------------------------------------------------
// first_seen_char_histogram_core
// Byte histogram kept in first-appearance order, built as a chain of
// TABLE_DEPTH entry cells.
// ----------------------------------------------------------------------------
// Every transaction walks the chain of entry cells one cell per clock while
// the result is not stalled, passing the stage register of each cell in
// turn, and a new transaction may enter in every cycle in which the chain
// advances.
// A stalled result holds the whole chain. Count transactions bump a
// matching entry (saturating) or append the byte at the first free cell;
// read transactions return the entry at entry_index; clear empties the
// table. No clearing pass is needed after reset.
module first_seen_char_histogram_core #(
  parameter int TABLE_DEPTH = fshist_pkg::DEF_TABLE_DEPTH,
  parameter int TALLY_BITS  = fshist_pkg::DEF_TALLY_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fshist_pkg::ACT_W-1:0]      in_action,
  input  logic [fshist_pkg::CHAR_W-1:0]     in_char_value,
  input  logic [fshist_pkg::INDEX_W-1:0]    in_entry_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fshist_pkg::DCNT_W-1:0]     out_distinct_count,
  output logic [fshist_pkg::CHAR_W-1:0]     out_entry_char,
  output logic [fshist_pkg::ECNT_W-1:0]     out_entry_count,
  output logic                              out_was_present,
  output logic                              out_overflow
);
  import fshist_pkg::*;
  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic                  vld   [TABLE_DEPTH+1];
  token_t                tok   [TABLE_DEPTH+1];
  logic [CNT_W-1:0]      used  [TABLE_DEPTH+1];
  logic [TALLY_BITS-1:0] tally [TABLE_DEPTH+1];
  logic                  adv;
  token_t                tok_in;
  token_t                tok_last;

  // Hold the chain while the result waits
  assign adv      = !vld[TABLE_DEPTH] || out_ready;
  assign in_ready = adv;

  // Build the entering transaction
  always_comb begin
    tok_in.action      = in_action;
    tok_in.char_value  = in_char_value;
    tok_in.entry_index = in_entry_index;
    tok_in.present     = 1'b0;
    tok_in.claimed     = 1'b0;
    tok_in.rchar       = TERM_CHAR;
  end
  assign tok[0]   = tok_in;
  assign vld[0]   = in_valid;
  assign used[0]  = '0;
  assign tally[0] = '0;

  // Chain of entry cells
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    fshist_cell #(
      .CELL_IDX   (k),
      .TALLY_BITS (TALLY_BITS),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv_i      (adv),
      .vld_i      (vld[k]),
      .tok_i      (tok[k]),
      .used_i     (used[k]),
      .tally_i    (tally[k]),
      .vld_o      (vld[k+1]),
      .tok_o      (tok[k+1]),
      .used_o     (used[k+1]),
      .tally_o    (tally[k+1])
    );
  end

  // Format the result from the last stage
  assign tok_last           = tok[TABLE_DEPTH];
  assign out_valid          = vld[TABLE_DEPTH];
  assign out_distinct_count = DCNT_W'(used[TABLE_DEPTH]);
  assign out_entry_char     = tok_last.rchar;
  assign out_entry_count    = ECNT_W'(tally[TABLE_DEPTH]);
  assign out_was_present    = tok_last.present;
  assign out_overflow       = (tok_last.action == ACT_COUNT) &&
                              (tok_last.char_value != TERM_CHAR) &&
                              !tok_last.present && !tok_last.claimed;

  // A dropped byte never also matched an entry
  `ASSERT_ALWAYS(a_ovf_not_hit, !(out_valid && out_overflow && out_was_present),
    "overflow together with hit")
  // Overflow only when every cell was in use as the transaction passed
  `ASSERT_IMPLY(a_ovf_full, out_valid && out_overflow,
    (used[TABLE_DEPTH] == CNT_W'(TABLE_DEPTH)), "overflow while table not full")
  // A clear leaves no entry behind
  `ASSERT_IMPLY(a_clear_empty, out_valid && (tok_last.action == ACT_CLEAR),
    (used[TABLE_DEPTH] == '0), "clear left entries in use")
  // A matched entry carries the counted byte
  `ASSERT_IMPLY(a_hit_char, out_valid && out_was_present,
    (out_entry_char == tok_last.char_value) && (out_entry_char != TERM_CHAR),
    "hit reports wrong byte")

endmodule

### verif/tb_first_seen_char_histogram_core.sv
// ----------------------------------------------------------------------------
// tb_first_seen_char_histogram_core
// Self-checking bench for the first-seen character histogram core. A table of
// directed transactions, a table-full sweep, a back-to-back burst on one byte
// and a long random run drive the input channel. Every accepted transaction
// goes through a behavioral histogram; each result is compared field by field
// with the oldest pending expectation. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_first_seen_char_histogram_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fshist_pkg::*;

  localparam int DEPTH      = DEF_TABLE_DEPTH;
  localparam int TALLY_BITS = DEF_TALLY_BITS;
  localparam logic [TALLY_BITS-1:0] TALLY_MAX = '1;
  localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;
  localparam int RANDOM_ITEMS = 1500;
  localparam int BURST_ITEMS  = 300;

  typedef struct packed {
    logic [DCNT_W-1:0] distinct;
    logic [CHAR_W-1:0] chr;
    logic [ECNT_W-1:0] cnt;
    logic              present;
    logic              ovf;
  } tally_result_t;

  typedef struct packed {
    logic [ACT_W-1:0]   act;
    logic [CHAR_W-1:0]  ch;
    logic [INDEX_W-1:0] idx;
    logic               typed;  // expectation written out in the table
    tally_result_t      want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready;
  logic [ACT_W-1:0]   in_action;
  logic [CHAR_W-1:0]  in_char_value;
  logic [INDEX_W-1:0] in_entry_index;
  logic out_valid, out_ready;
  logic [DCNT_W-1:0] out_distinct_count;
  logic [CHAR_W-1:0] out_entry_char;
  logic [ECNT_W-1:0] out_entry_count;
  logic out_was_present, out_overflow;

  // Behavioral copy of the histogram
  logic [CHAR_W-1:0]     seen_char  [DEPTH];
  logic [TALLY_BITS-1:0] seen_tally [DEPTH];
  int                    seen_used;

  tally_result_t pending_tallies[$];
  bit idle_on;
  int mismatch_cnt, items_sent, results_seen, overflow_seen, saturated_seen;

  // Directed transactions, expected values filled in where obvious
  stim_row_t script [19] = '{
    {ACT_READ,    8'h00, 7'd0,   1'b1, 8'd0, 8'h00, 16'd0, 1'b0, 1'b0},
    {ACT_COUNT,   8'h00, 7'd0,   1'b1, 8'd0, 8'h00, 16'd0, 1'b0, 1'b0},
    {ACT_UNKNOWN, 8'hFF, 7'd127, 1'b1, 8'd0, 8'h00, 16'd0, 1'b0, 1'b0},
    {ACT_COUNT,   8'hFF, 7'd0,   1'b1, 8'd1, 8'hFF, 16'd1, 1'b0, 1'b0},
    {ACT_COUNT,   8'h01, 7'd127, 1'b1, 8'd2, 8'h01, 16'd1, 1'b0, 1'b0},
    {ACT_COUNT,   8'hFF, 7'd0,   1'b1, 8'd2, 8'hFF, 16'd2, 1'b1, 1'b0},
    {ACT_READ,    8'h00, 7'd0,   1'b1, 8'd2, 8'hFF, 16'd2, 1'b0, 1'b0},
    {ACT_READ,    8'hFF, 7'd1,   1'b1, 8'd2, 8'h01, 16'd1, 1'b0, 1'b0},
    {ACT_READ,    8'h00, 7'd127, 1'b1, 8'd2, 8'h00, 16'd0, 1'b0, 1'b0},
    {ACT_COUNT,   8'h80, 7'd0,   1'b1, 8'd3, 8'h80, 16'd1, 1'b0, 1'b0},
    {ACT_COUNT,   8'h7F, 7'd0,   1'b1, 8'd4, 8'h7F, 16'd1, 1'b0, 1'b0},
    {ACT_COUNT,   8'h00, 7'd127, 1'b1, 8'd4, 8'h00, 16'd0, 1'b0, 1'b0},
    {ACT_READ,    8'hFF, 7'd2,   1'b1, 8'd4, 8'h80, 16'd1, 1'b0, 1'b0},
    {ACT_UNKNOWN, 8'h00, 7'd0,   1'b1, 8'd4, 8'h00, 16'd0, 1'b0, 1'b0},
    {ACT_CLEAR,   8'hFF, 7'd127, 1'b1, 8'd0, 8'h00, 16'd0, 1'b0, 1'b0},
    {ACT_READ,    8'h00, 7'd0,   1'b1, 8'd0, 8'h00, 16'd0, 1'b0, 1'b0},
    {ACT_COUNT,   8'h01, 7'd0,   1'b1, 8'd1, 8'h01, 16'd1, 1'b0, 1'b0},
    {ACT_COUNT,   8'hAA, 7'd55,  1'b0, 34'd0},
    {ACT_COUNT,   8'h01, 7'd42,  1'b0, 34'd0}
  };

  first_seen_char_histogram_core #(
    .TABLE_DEPTH(DEPTH),
    .TALLY_BITS (TALLY_BITS)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_char_value     (in_char_value),
    .in_entry_index    (in_entry_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_distinct_count(out_distinct_count),
    .out_entry_char    (out_entry_char),
    .out_entry_count   (out_entry_count),
    .out_was_present   (out_was_present),
    .out_overflow      (out_overflow)
  );

  always #6 clk = ~clk;

  // Apply one transaction to the behavioral histogram and return its result
  function automatic tally_result_t tally_predict(input logic [ACT_W-1:0] act,
                                                  input logic [CHAR_W-1:0] ch,
                                                  input logic [INDEX_W-1:0] idx);
    tally_result_t r;
    int pos;
    r = '0;
    pos = -1;
    case (act)
      ACT_COUNT: begin
        if (ch != TERM_CHAR) begin
          for (int k = 0; k < seen_used; k++)
            if (pos < 0 && seen_char[k] == ch) pos = k;
          if (pos >= 0) begin
            if (seen_tally[pos] != TALLY_MAX) seen_tally[pos]++;
            r.chr     = ch;
            r.cnt     = seen_tally[pos][ECNT_W-1:0];
            r.present = 1'b1;
          end else if (seen_used < DEPTH) begin
            seen_char[seen_used]  = ch;
            seen_tally[seen_used] = TALLY_BITS'(1);
            seen_used++;
            r.chr = ch;
            r.cnt = ECNT_W'(1);
          end else begin
            r.ovf = 1'b1;
          end
        end
      end
      ACT_READ: begin
        if (int'(idx) < seen_used) begin
          r.chr = seen_char[idx];
          r.cnt = seen_tally[idx][ECNT_W-1:0];
        end
      end
      ACT_CLEAR: begin
        seen_used = 0;
      end
      default: ;
    endcase
    r.distinct = seen_used[DCNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // Drive one transaction after a random gap while idling is on, then predict it on acceptance
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [CHAR_W-1:0] ch,
                           input logic [INDEX_W-1:0] idx, input bit typed = 1'b0,
                           input tally_result_t want = '0);
    int gap;
    tally_result_t pred;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_char_value  <= ch;
    in_entry_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = tally_predict(act, ch, idx);
    pending_tallies.push_back(typed ? want : pred);
    items_sent++;
  endtask

  // Hold off the sender until every pending result has returned
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_tallies.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, compare each transaction with the oldest prediction
  initial begin : result_sink
    int stall;
    tally_result_t want;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_on ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      results_seen++;
      if (pending_tallies.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_entry_char), 32'd0);
      end else begin
        want = pending_tallies.pop_front();
        if (want.ovf) overflow_seen++;
        if (want.present && want.cnt == TALLY_MAX[ECNT_W-1:0]) saturated_seen++;
        if (out_distinct_count !== want.distinct)
          report_mismatch("distinct_count", 32'(out_distinct_count), 32'(want.distinct));
        if (out_entry_char !== want.chr)
          report_mismatch("entry_char", 32'(out_entry_char), 32'(want.chr));
        if (out_entry_count !== want.cnt)
          report_mismatch("entry_count", 32'(out_entry_count), 32'(want.cnt));
        if (out_was_present !== want.present)
          report_mismatch("was_present", 32'(out_was_present), 32'(want.present));
        if (out_overflow !== want.ovf)
          report_mismatch("overflow", 32'(out_overflow), 32'(want.ovf));
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int pick;
    bit wide_mode;
    logic [ACT_W-1:0]   act;
    logic [CHAR_W-1:0]  ch;
    logic [INDEX_W-1:0] idx;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_action      <= ACT_COUNT;
    in_char_value  <= '0;
    in_entry_index <= '0;
    seen_used = 0;
    idle_on   = 1'b1;
    wide_mode = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (script[i])
      send_item(script[i].act, script[i].ch, script[i].idx, script[i].typed, script[i].want);

    // Fill the table, then push past it
    send_item(ACT_CLEAR, 8'h00, 7'd0);
    for (int b = 1; b <= DEPTH; b++) send_item(ACT_COUNT, CHAR_W'(b), 7'd0);
    send_item(ACT_COUNT, 8'hC8, 7'd0);
    send_item(ACT_COUNT, 8'hFE, 7'd0);
    send_item(ACT_COUNT, 8'h00, 7'd0);
    send_item(ACT_COUNT, 8'h05, 7'd0);
    send_item(ACT_READ, 8'h00, 7'd127);
    send_item(ACT_READ, 8'h00, 7'd0);
    drain_results();

    // Hammer one byte back to back
    idle_on = 1'b0;
    send_item(ACT_CLEAR, 8'h00, 7'd0);
    repeat (BURST_ITEMS) send_item(ACT_COUNT, 8'h5A, 7'd0);
    send_item(ACT_READ, 8'h00, 7'd0);
    send_item(ACT_READ, 8'h00, 7'd1);

    // Random traffic: mostly counts over a few letters or all bytes
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 250 == 0) begin
        idle_on   = ($urandom_range(0, 3) != 0);
        wide_mode = $urandom_range(0, 1);
      end
      if (n == RANDOM_ITEMS / 2) drain_results();
      pick = $urandom_range(0, 99);
      ch   = CHAR_W'($urandom_range(0, 255));
      idx  = INDEX_W'($urandom_range(0, 127));
      if (pick < 2) begin
        act = ACT_CLEAR;
      end else if (pick < 4) begin
        act = ACT_UNKNOWN;
      end else if (pick < 22) begin
        act = ACT_READ;
        if (seen_used > 0 && $urandom_range(0, 3) != 0)
          idx = INDEX_W'($urandom_range(0, seen_used - 1));
      end else begin
        act = ACT_COUNT;
        if ($urandom_range(0, 99) < 3) ch = TERM_CHAR;
        else if (wide_mode) ch = CHAR_W'($urandom_range(1, 255));
        else ch = 8'h61 + CHAR_W'($urandom_range(0, 7));
      end
      send_item(act, ch, idx);
    end

    // Wrap up: let the chain empty, then watch for stray results
    in_valid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (DEPTH + 32) @(posedge clk);
    $display("Sent %0d transactions (count, read, clear, unknown), checked %0d results",
             items_sent, results_seen);
    $display("Table overflow drops seen: %0d, saturated counts seen: %0d",
             overflow_seen, saturated_seen);
    if (mismatch_cnt == 0 && pending_tallies.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(10_000_000);
    $display("Timeout with %0d results pending", pending_tallies.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
